>>> design/fwh_pkg.sv
// fwh_pkg: shared types and constants for the fixed-width histogram
// used by fwh_front, fwh_cmdq, fwh_back and the top module; no dependencies

package fwh_pkg;

   localparam int NUM_BUCKETS = 256;
   localparam int IDX_W       = $clog2(NUM_BUCKETS);
   localparam int ACT_W       = IDX_W + 1;
   localparam int WIDTH_W     = 32;
   localparam int KEY_W       = 48;
   localparam int AMT_W       = 32;
   localparam int COUNT_W     = 64;
   localparam int PROD_W      = ACT_W + WIDTH_W;
   localparam int DSR_W       = WIDTH_W + IDX_W;
   localparam int STEP_W      = $clog2(IDX_W);
   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic OP_INC  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BUCKET_WIDTH   = 1'b0,
      CSR_ACTIVE_BUCKETS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_CHK,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic {
      B_IDLE,
      B_DATA
   } back_state_type;

   typedef struct packed {
      logic                    op;
      logic [IDX_W-1:0]        idx;
      logic signed [AMT_W-1:0] amount;
      logic                    clamped;
   } cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0]   bucket;
      logic [COUNT_W-1:0] count;
      logic               clamped;
   } rsp_type;

endpackage

>>> design/fwh_ram.sv
// fwh_ram: generic single-write, single-read ram with registered read data
// no dependencies

module fwh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/fwh_front.sv
// fwh_front: accepts requests and bins the key into a bucket index
// uses fwh_pkg; multiply for the overflow check, then a bit-serial divide

module fwh_front import fwh_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic                     req_op,
   input  logic [KEY_W-1:0]         req_key,
   input  logic signed [AMT_W-1:0]  req_amount,
   input  logic [IDX_W-1:0]         req_read_bucket,
   input  logic [WIDTH_W-1:0]       bucket_width,
   input  logic [ACT_W-1:0]         active_buckets,
   input  logic                     cq_full,
   output logic                     cq_push,
   output cmd_type                  cq_cmd
);

   front_state_type         state_ff, state_in;
   logic                    op_ff;
   logic signed [AMT_W-1:0] amount_ff;
   logic [WIDTH_W-1:0]      w_ff;
   logic [ACT_W-1:0]        act_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [KEY_W-1:0]        rem_ff;
   logic [DSR_W-1:0]        dsr_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic                    clamped_ff;
   logic                    accept;
   logic                    over;
   logic                    ge;
   logic [WIDTH_W-1:0]      w_eff;
   logic [ACT_W-1:0]        act_eff;

   assign accept = push && !full;
   assign over   = rem_ff >= KEY_W'(prod_ff);
   assign ge     = rem_ff >= KEY_W'(dsr_ff);

   always_comb begin
      w_eff = (bucket_width == '0) ? WIDTH_W'(1) : bucket_width;
      if (active_buckets == '0) begin
         act_eff = ACT_W'(1);
      end else if (active_buckets > ACT_W'(NUM_BUCKETS)) begin
         act_eff = ACT_W'(NUM_BUCKETS);
      end else begin
         act_eff = active_buckets;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = (req_op == OP_READ) ? F_PUSH : F_MUL;
            end
         end
         F_MUL: state_in = F_CHK;
         F_CHK: state_in = over ? F_PUSH : F_DIV;
         F_DIV: begin
            if (step_ff == '0) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!cq_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      full    = 1'b1;
      cq_push = 1'b0;
      case (state_ff)
         F_IDLE:  full = 1'b0;
         F_PUSH:  cq_push = !cq_full;
         default: begin
            full    = 1'b1;
            cq_push = 1'b0;
         end
      endcase
   end

   assign cq_cmd = '{op: op_ff, idx: idx_ff, amount: amount_ff, clamped: clamped_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               op_ff      <= req_op;
               amount_ff  <= req_amount;
               rem_ff     <= req_key;
               w_ff       <= w_eff;
               act_ff     <= act_eff;
               idx_ff     <= req_read_bucket;
               clamped_ff <= 1'b0;
            end
         end
         F_MUL: prod_ff <= act_ff * w_ff;
         F_CHK: begin
            if (over) begin
               idx_ff     <= IDX_W'(act_ff - ACT_W'(1));
               clamped_ff <= 1'b1;
            end else begin
               idx_ff  <= '0;
               dsr_ff  <= DSR_W'(w_ff) << (IDX_W - 1);
               step_ff <= STEP_W'(IDX_W - 1);
            end
         end
         F_DIV: begin
            if (ge) begin
               rem_ff <= rem_ff - KEY_W'(dsr_ff);
            end
            idx_ff  <= {idx_ff[IDX_W-2:0], ge};
            dsr_ff  <= dsr_ff >> 1;
            step_ff <= step_ff - STEP_W'(1);
         end
         default: begin
         end
      endcase
   end

endmodule

>>> design/fwh_cmdq.sv
// fwh_cmdq: short register queue of binned commands between front and back
// uses fwh_pkg

module fwh_cmdq import fwh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   cmd_type               mem_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CMDQ_CNT_W-1:0] cnt_ff;
   logic                  do_push;
   logic                  do_pop;

   assign full    = cnt_ff == CMDQ_CNT_W'(CMDQ_DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                         : wr_ptr_ff + CMDQ_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                         : rd_ptr_ff + CMDQ_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CMDQ_CNT_W'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CMDQ_CNT_W'(1);
         end
      end
   end

endmodule

>>> design/fwh_back.sv
// fwh_back: counter read-modify-write and the result register
// uses fwh_pkg and fwh_ram

module fwh_back import fwh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cq_empty,
   input  cmd_type cq_cmd,
   output logic    cq_pop,
   input  logic    pop,
   output logic    empty,
   output rsp_type rsp
);

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff;
   rsp_type            rsp_ff;
   logic               out_valid_ff;
   logic [NUM_BUCKETS-1:0] valid_ff;
   logic               ram_we;
   logic               ram_re;
   logic [COUNT_W-1:0] ram_rdata;
   logic [COUNT_W-1:0] cur;
   logic [COUNT_W-1:0] sum;
   logic               start;

   fwh_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (NUM_BUCKETS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (cmd_ff.idx),
      .wdata (sum),
      .re    (ram_re),
      .raddr (cq_cmd.idx),
      .rdata (ram_rdata)
   );

   assign start = !cq_empty && !out_valid_ff;
   assign cur   = valid_ff[cmd_ff.idx] ? ram_rdata : '0;
   assign sum   = cur + {{(COUNT_W - AMT_W){cmd_ff.amount[AMT_W-1]}}, cmd_ff.amount};
   assign empty = !out_valid_ff;
   assign rsp   = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (start) begin
               state_in = B_DATA;
            end
         end
         B_DATA:  state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cq_pop = 1'b0;
      ram_re = 1'b0;
      ram_we = 1'b0;
      case (state_ff)
         B_IDLE: begin
            cq_pop = start;
            ram_re = start;
         end
         B_DATA:  ram_we = cmd_ff.op == OP_INC;
         default: begin
            cq_pop = 1'b0;
            ram_re = 1'b0;
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cq_pop) begin
         cmd_ff <= cq_cmd;
      end
      if (state_ff == B_DATA) begin
         rsp_ff.bucket  <= cmd_ff.idx;
         rsp_ff.count   <= (cmd_ff.op == OP_INC) ? sum : cur;
         rsp_ff.clamped <= (cmd_ff.op == OP_INC) && cmd_ff.clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_DATA) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
         if (ram_we) begin
            valid_ff[cmd_ff.idx] <= 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_DATA |-> !out_valid_ff)
      else $error("result register overwritten");

   a_pop_to_data: assert property (@(posedge clock) disable iff (reset)
      cq_pop |=> state_ff == B_DATA)
      else $error("command popped without counter access");

   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DATA && cmd_ff.op == OP_READ) |-> !ram_we)
      else $error("read request wrote the counter store");

   a_marked_valid: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> valid_ff[$past(cmd_ff.idx)])
      else $error("written counter not marked valid");
`endif

endmodule

>>> design/fixed_width_histogram_top.sv
// fixed_width_histogram_top: increments do multiply, compare, 8-step divide, queue push,
// counter read-modify-write; a clamped key skips the divide, a read goes to the queue push
// and reads its counter; the front takes a new request only once it has pushed the last;
// a result left unpopped holds the back and stalls the front once the 2-entry queue fills
// reset (synchronous): queues empty, all counters read as zero, bucket_width 1, 256 buckets
// uses fwh_pkg, fwh_front, fwh_cmdq, fwh_back

module fixed_width_histogram_top import fwh_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic                    req_op,
   input  logic [KEY_W-1:0]        req_key,
   input  logic signed [AMT_W-1:0] req_amount,
   input  logic [IDX_W-1:0]        req_read_bucket,
   output logic                    empty,
   input  logic                    pop,
   output logic [IDX_W-1:0]        rsp_bucket,
   output logic [COUNT_W-1:0]      rsp_count,
   output logic                    rsp_clamped,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   logic [WIDTH_W-1:0] bucket_width_ff;
   logic [ACT_W-1:0]   active_buckets_ff;
   logic               fq_push;
   logic               fq_full;
   cmd_type            fq_cmd;
   logic               bq_pop;
   logic               bq_empty;
   cmd_type            bq_cmd;
   rsp_type            rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_width_ff   <= WIDTH_W'(1);
         active_buckets_ff <= ACT_W'(NUM_BUCKETS);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BUCKET_WIDTH:   bucket_width_ff   <= csr_wdata[WIDTH_W-1:0];
            CSR_ACTIVE_BUCKETS: active_buckets_ff <= csr_wdata[ACT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   fwh_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_op          (req_op),
      .req_key         (req_key),
      .req_amount      (req_amount),
      .req_read_bucket (req_read_bucket),
      .bucket_width    (bucket_width_ff),
      .active_buckets  (active_buckets_ff),
      .cq_full         (fq_full),
      .cq_push         (fq_push),
      .cq_cmd          (fq_cmd)
   );

   fwh_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (fq_push),
      .push_cmd (fq_cmd),
      .full     (fq_full),
      .pop      (bq_pop),
      .pop_cmd  (bq_cmd),
      .empty    (bq_empty)
   );

   fwh_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cq_empty (bq_empty),
      .cq_cmd   (bq_cmd),
      .cq_pop   (bq_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp      (rsp)
   );

   assign rsp_bucket  = rsp.bucket;
   assign rsp_count   = rsp.count;
   assign rsp_clamped = rsp.clamped;

endmodule
